// ===== src/sbndm_pkg.sv =====
package sbndm_pkg;

    // Default sizes of the stores.
    localparam int TEXT_DEPTH_DEF  = 4096;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int ALPHABET_DEF    = 256;

    // The bit-parallel word is fixed at 32 bits.
    localparam int WORD     = 32;
    localparam int WORD_LOG = 5;
    localparam int LEN_W    = 6;
    localparam int COUNT_W  = 13;

    // Request kinds.
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SHORT    = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic [1:0]         status;
    } out_item_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BLD_RD,
        ST_BLD_WR,
        ST_SH_INIT,
        ST_SH_RD,
        ST_SH_UPD,
        ST_CP,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_CMP_END,
        ST_SC_TEST,
        ST_SC_RDT,
        ST_SC_RDM,
        ST_SC_D0,
        ST_SC_RDTJ,
        ST_SC_RDMJ,
        ST_SC_DJ,
        ST_SC_RES,
        ST_FINISH
    } ctrl_state_t;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_BLD_RD,
        OP_BLD_WR,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_UPD,
        OP_CP,
        OP_CMP_RD,
        OP_CMP_CHK,
        OP_CMP_END,
        OP_SC_RDT,
        OP_SC_RDM,
        OP_SC_D0,
        OP_SC_RDTJ,
        OP_SC_RDMJ,
        OP_SC_DJ,
        OP_SC_RES,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_text;
        logic bad_len;
        logic k_end;
        logic k_zero;
        logic i_lt;
        logic sc_stop;
        logic sc_break;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== src/sbndm_ctrl.sv =====
module sbndm_ctrl import sbndm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.load   = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && st.last_text) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.op     = OP_CLEAR;
                state_next = st.bad_len ? ST_FINISH : ST_BLD_RD;
            end
            ST_BLD_RD: begin
                cmd.op     = OP_BLD_RD;
                state_next = ST_BLD_WR;
            end
            ST_BLD_WR: begin
                cmd.op     = OP_BLD_WR;
                state_next = st.k_end ? ST_SH_INIT : ST_BLD_RD;
            end
            ST_SH_INIT: begin
                cmd.op     = OP_SH_INIT;
                state_next = ST_SH_RD;
            end
            ST_SH_RD: begin
                cmd.op     = OP_SH_RD;
                state_next = ST_SH_UPD;
            end
            ST_SH_UPD: begin
                cmd.op     = OP_SH_UPD;
                state_next = st.k_zero ? ST_CP : ST_SH_RD;
            end
            ST_CP: begin
                cmd.op     = OP_CP;
                state_next = st.k_end ? ST_CMP_RD : ST_CP;
            end
            ST_CMP_RD: begin
                cmd.op     = OP_CMP_RD;
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK: begin
                cmd.op     = OP_CMP_CHK;
                state_next = st.k_end ? ST_CMP_END : ST_CMP_RD;
            end
            ST_CMP_END: begin
                cmd.op     = OP_CMP_END;
                state_next = ST_SC_TEST;
            end
            ST_SC_TEST: begin
                state_next = st.i_lt ? ST_SC_RDT : ST_FINISH;
            end
            ST_SC_RDT: begin
                cmd.op     = OP_SC_RDT;
                state_next = ST_SC_RDM;
            end
            ST_SC_RDM: begin
                cmd.op     = OP_SC_RDM;
                state_next = ST_SC_D0;
            end
            ST_SC_D0: begin
                cmd.op     = OP_SC_D0;
                state_next = ST_SC_RDTJ;
            end
            ST_SC_RDTJ: begin
                cmd.op     = OP_SC_RDTJ;
                state_next = ST_SC_RDMJ;
            end
            ST_SC_RDMJ: begin
                cmd.op     = OP_SC_RDMJ;
                state_next = ST_SC_DJ;
            end
            ST_SC_DJ: begin
                cmd.op     = OP_SC_DJ;
                state_next = st.sc_stop ? ST_SC_RES : ST_SC_RDTJ;
            end
            ST_SC_RES: begin
                cmd.op     = OP_SC_RES;
                state_next = st.sc_break ? ST_FINISH : ST_SC_TEST;
            end
            ST_FINISH: begin
                if (!st.out_busy) begin
                    cmd.op     = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sbndm_datapath.sv =====
module sbndm_datapath import sbndm_pkg::*; #(
    parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int ALPHABET    = ALPHABET_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  in_item_t         s_data,
    input  dp_cmd_t          cmd,
    output dp_status_t       st,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int SLOTS = TEXT_DEPTH + MAX_PATTERN;
    localparam int TW    = $clog2(SLOTS);
    localparam int IW    = $clog2(SLOTS + 1);
    localparam int PAW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PCW   = $clog2(MAX_PATTERN + 1);
    localparam int AW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam logic [16:0] RECIP = 17'(65536 / ALPHABET);
    localparam logic [16:0] ALPH  = 17'(ALPHABET);

    // Configuration and load counters.
    logic [LEN_W-1:0] m_reg;
    logic [PCW-1:0]   pcnt_reg;
    logic [IW-1:0]    tcnt_reg;
    logic             ovf_reg;

    // Search registers.
    logic [IW-1:0]    n_reg;
    logic             ovfs_reg;
    logic [LEN_W-1:0] k_reg;
    logic [IW-1:0]    i_reg;
    logic [IW-1:0]    j_reg;
    logic [WORD-1:0]  d_reg;
    logic [WORD-1:0]  s_reg;
    logic [LEN_W-1:0] last_reg;
    logic             eq_reg;
    logic [IW-1:0]    count_reg;
    logic [AW-1:0]    baddr_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    // Stores.
    logic [7:0]      pat_mem [MAX_PATTERN];
    logic [7:0]      text_mem [SLOTS];
    logic [7:0]      text_q;
    logic [WORD-1:0] mask_mem [ALPHABET];
    logic [WORD-1:0] mask_q;
    logic [ALPHABET-1:0] mvalid_reg;
    logic            mvalid_q;

    logic [LEN_W-1:0] pat_addr;
    logic [7:0]       pat_byte;
    logic [7:0]       mask_byte;
    logic [24:0]      fold_prod;
    logic [16:0]      fold_rem;
    logic [AW-1:0]    mask_raddr;
    logic [WORD-1:0]  mval;
    logic [WORD-1:0]  bit_sel;
    logic [LEN_W-1:0] bit_pos;
    logic [WORD-1:0]  s_and;
    logic [WORD-1:0]  d_step;
    logic             mask_we;
    logic             txt_we;
    logic [IW-1:0]    txt_waddr;
    logic [7:0]       txt_wdata;
    logic [IW-1:0]    txt_raddr;
    logic             pat_load;
    logic             txt_load;
    logic             txt_room;
    logic [IW:0]      end_pos;
    logic [IW+COUNT_W-1:0] cnt_ext;

    // Pattern read port and mask bit for the build pass.
    always_comb begin
        pat_addr = (cmd.op == OP_BLD_RD) ? LEN_W'(m_reg - 6'd1 - k_reg) : k_reg;
        pat_byte = pat_mem[pat_addr[PAW-1:0]];
        bit_pos  = LEN_W'(k_reg + LEN_W'(WORD) - m_reg);
        bit_sel  = WORD'(1) << bit_pos[WORD_LOG-1:0];
    end

    // Fold a byte into the alphabet with a reciprocal multiply and one correction.
    always_comb begin
        mask_byte = (cmd.op == OP_BLD_RD || cmd.op == OP_SH_RD) ? pat_byte : text_q;
        fold_prod = {17'b0, mask_byte} * RECIP;
        fold_rem  = {9'b0, mask_byte} - ({9'b0, fold_prod[23:16]} * ALPH);
        if (fold_rem >= ALPH) begin
            fold_rem = fold_rem - ALPH;
        end
        mask_raddr = fold_rem[AW-1:0];
        mval       = mvalid_q ? mask_q : '0;
        s_and      = s_reg & mval;
        d_step     = {d_reg[WORD-2:0], 1'b0} & mval;
    end

    // Text store write and read selection.
    always_comb begin
        pat_load  = cmd.load && (s_data.req_type == REQ_PATTERN);
        txt_load  = cmd.load && (s_data.req_type == REQ_TEXT);
        txt_room  = (int'(tcnt_reg) < TEXT_DEPTH);
        txt_we    = (txt_load && txt_room) || (cmd.op == OP_CP);
        txt_waddr = (cmd.op == OP_CP) ? IW'(n_reg + IW'(k_reg)) : tcnt_reg;
        txt_wdata = (cmd.op == OP_CP) ? pat_byte : s_data.data_byte;
        case (cmd.op)
            OP_CMP_RD:  txt_raddr = IW'(k_reg);
            OP_SC_RDT:  txt_raddr = i_reg;
            default:    txt_raddr = j_reg;
        endcase
        mask_we = (cmd.op == OP_BLD_WR);
        end_pos = {1'b0, n_reg} + (IW+1)'(m_reg);
    end

    // Status back to the controller.
    always_comb begin
        st.last_text = (s_data.req_type == REQ_TEXT) && s_data.is_last;
        st.bad_len   = (m_reg < 6'd2) || (int'(m_reg) > MAX_PATTERN) || (int'(m_reg) > WORD);
        st.k_end     = (k_reg == LEN_W'(m_reg - 6'd1));
        st.k_zero    = (k_reg == '0);
        st.i_lt      = ({1'b0, i_reg} < end_pos);
        st.sc_stop   = (({1'b0, j_reg} + (IW+1)'(m_reg)) == ({1'b0, i_reg} + 1'b1))
                       || (d_step == '0);
        st.sc_break  = (d_reg != '0) && (i_reg >= n_reg);
        st.out_busy  = out_valid_reg && !m_ready;
    end

    // Pattern register file.
    always_ff @(posedge aclk) begin
        if (pat_load && (int'(pcnt_reg) < MAX_PATTERN)) begin
            pat_mem[pcnt_reg[PAW-1:0]] <= s_data.data_byte;
        end
    end

    // Text memory with registered read.
    always_ff @(posedge aclk) begin
        if (txt_we) begin
            text_mem[txt_waddr[TW-1:0]] <= txt_wdata;
        end
        text_q <= text_mem[txt_raddr[TW-1:0]];
    end

    // Mask table memory with registered read.
    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_mem[baddr_reg] <= mval | bit_sel;
        end
        mask_q <= mask_mem[mask_raddr];
    end

    // Mask valid bits; an entry not written in this search reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= '0;
            mvalid_q   <= 1'b0;
        end else begin
            if (cmd.op == OP_CLEAR) begin
                mvalid_reg <= '0;
            end else if (mask_we) begin
                mvalid_reg[baddr_reg] <= 1'b1;
            end
            mvalid_q <= mvalid_reg[mask_raddr];
        end
    end

    // Configuration and load counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_reg    <= LEN_W'(2);
            pcnt_reg <= '0;
            tcnt_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                m_reg <= cfg_wr_data;
            end
            if (pat_load && (int'(pcnt_reg) < MAX_PATTERN)) begin
                pcnt_reg <= PCW'(pcnt_reg + 1'b1);
            end
            if (txt_load) begin
                if (s_data.is_last) begin
                    pcnt_reg <= '0;
                    tcnt_reg <= '0;
                    ovf_reg  <= 1'b0;
                end else if (txt_room) begin
                    tcnt_reg <= IW'(tcnt_reg + 1'b1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // Search datapath registers.
    always_ff @(posedge aclk) begin
        if (txt_load && s_data.is_last) begin
            n_reg    <= txt_room ? IW'(tcnt_reg + 1'b1) : tcnt_reg;
            ovfs_reg <= ovf_reg || !txt_room;
        end
        case (cmd.op)
            OP_CLEAR: begin
                k_reg     <= '0;
                count_reg <= '0;
                eq_reg    <= (n_reg >= IW'(m_reg));
            end
            OP_BLD_RD: begin
                baddr_reg <= mask_raddr;
            end
            OP_BLD_WR: begin
                k_reg <= LEN_W'(k_reg + 1'b1);
            end
            OP_SH_INIT: begin
                k_reg    <= LEN_W'(m_reg - 6'd1);
                s_reg    <= '1;
                last_reg <= m_reg;
            end
            OP_SH_UPD: begin
                if (s_and[WORD-1] && (k_reg != '0)) begin
                    last_reg <= k_reg;
                end
                s_reg <= {s_and[WORD-2:0], 1'b0};
                if (k_reg != '0) begin
                    k_reg <= LEN_W'(k_reg - 1'b1);
                end
            end
            OP_CP: begin
                k_reg <= st.k_end ? '0 : LEN_W'(k_reg + 1'b1);
            end
            OP_CMP_CHK: begin
                eq_reg <= eq_reg && (text_q == pat_byte);
                k_reg  <= LEN_W'(k_reg + 1'b1);
            end
            OP_CMP_END: begin
                count_reg <= IW'(eq_reg);
                i_reg     <= IW'(m_reg);
            end
            OP_SC_D0: begin
                d_reg <= mval;
                j_reg <= IW'(i_reg - 1'b1);
            end
            OP_SC_DJ: begin
                d_reg <= d_step;
                if (!st.sc_stop) begin
                    j_reg <= IW'(j_reg - 1'b1);
                end
            end
            OP_SC_RES: begin
                if (d_reg != '0) begin
                    if (i_reg < n_reg) begin
                        count_reg <= IW'(count_reg + 1'b1);
                        i_reg     <= IW'(i_reg + IW'(last_reg));
                    end
                end else begin
                    i_reg <= IW'(j_reg + IW'(m_reg));
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    assign cnt_ext = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_PUBLISH) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_PUBLISH) begin
            if (st.bad_len) begin
                out_data_reg.match_count <= '0;
                out_data_reg.status      <= STAT_SHORT;
            end else begin
                out_data_reg.match_count <= cnt_ext[COUNT_W-1:0];
                out_data_reg.status      <= ovfs_reg ? STAT_OVERFLOW : STAT_OK;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/sbndm_string_match_counter_unit.sv =====
// Simplified BNDM occurrence counter.
// Input channel (s_valid/s_ready/s_data): pattern bytes first (req_type 0), then
// text bytes (req_type 1), each taken while the block is idle.
// The text byte with is_last set starts the search; the next transaction is
// accepted only after the search has ended and its result is in the output register.
// Result channel (m_valid/m_ready/m_data): one transaction per search with the
// match count and a status (ok, pattern length unusable, text overflowed).
// The pattern length register is written through cfg_wr_en/cfg_wr_data; the user
// must do so only while idle, the block itself does not enforce this. After the
// last byte the block builds the mask table, copies the pattern behind the text as
// a sentinel and checks for a hit at position zero, then reads each window's text
// bytes backward from its end (at least one), each via the text memory read and
// then the mask table read, and publishes; an unusable length skips the search.
// The output register lets a new pattern and text load while a result waits;
// a stalled receiver holds only the next search at its end.
// Reset is synchronous and active low: the pattern length returns to 2, the
// load counters clear, no result is pending. The stores keep their contents.
module sbndm_string_match_counter_unit import sbndm_pkg::*; #(
    parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int ALPHABET    = ALPHABET_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    // Sequencer.
    sbndm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Stores, search registers and output register.
    sbndm_datapath #(
        .TEXT_DEPTH  (TEXT_DEPTH),
        .MAX_PATTERN (MAX_PATTERN),
        .ALPHABET    (ALPHABET)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .st          (st),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // A final text byte closes the input until the search is done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.req_type == REQ_TEXT && s_data.is_last) |=> !s_ready)
        else $error("input still open after the final text byte");

    // An unusable pattern length never reports matches.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_SHORT) |-> (m_data.match_count == '0))
        else $error("matches reported with an unusable pattern length");

    // Only defined status codes leave the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STAT_OK || m_data.status == STAT_SHORT
                     || m_data.status == STAT_OVERFLOW))
        else $error("undefined status code");

endmodule

// ===== test/sbndm_match_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the length register, predicts the count of each
// search and compares it with the transactions that come out of the block.
module sbndm_match_checker import sbndm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_item_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_item_t        m_data,
    output int               mismatches,
    output int               waiting_counts
);

    localparam int TXT_DEPTH = TEXT_DEPTH_DEF;
    localparam int PAT_MAX   = MAX_PATTERN_DEF;
    localparam int TXT_SLOTS = TXT_DEPTH + PAT_MAX;

    // Shadow copy of the block's stores and counters.
    logic [7:0]       pat_mem [PAT_MAX];
    logic [7:0]       txt_mem [TXT_SLOTS];
    logic [WORD-1:0]  bit_masks [ALPHABET_DEF];
    logic [LEN_W-1:0] pat_len;
    int               pat_seen;
    int               txt_seen;
    logic             txt_overflow;
    out_item_t        count_fifo [$];

    initial begin
        for (int k = 0; k < PAT_MAX; k++) pat_mem[k] = '0;
        for (int k = 0; k < TXT_SLOTS; k++) txt_mem[k] = '0;
    end

    function automatic logic [7:0] text_byte_at(input int idx);
        return (idx < TXT_SLOTS) ? txt_mem[idx] : 8'h00;
    endfunction

    // Counts occurrences of the m-byte pattern in the first n text bytes.
    function automatic int count_occurrences(input int m, input int n);
        logic [WORD-1:0] s;
        logic [WORD-1:0] d;
        int              skip;
        int              total;
        int              i;
        int              j;
        int              first;
        bit              same;
        for (int c = 0; c < ALPHABET_DEF; c++) bit_masks[c] = '0;
        for (int k = 0; k < m; k++)
            bit_masks[pat_mem[m-1-k]] |= 32'h1 << (k + WORD - m);

        // Shift used after a hit: the shortest restart that keeps a prefix.
        skip = m;
        s    = '1;
        for (int k = m - 1; k >= 0; k--) begin
            s &= bit_masks[pat_mem[k]];
            if (s[WORD-1] && k > 0) skip = k;
            s = s << 1;
        end

        // The pattern is placed after the text so the scan always stops.
        for (int k = 0; k < m; k++) txt_mem[n+k] = pat_mem[k];

        total = 0;
        if (n >= m) begin
            same = 1'b1;
            for (int k = 0; k < m; k++)
                if (pat_mem[k] != txt_mem[k]) same = 1'b0;
            if (same) total = 1;
        end

        i = m;
        while (i < n + m) begin
            d     = bit_masks[text_byte_at(i)];
            j     = i - 1;
            first = i - m + 1;
            forever begin
                d = (d << 1) & bit_masks[text_byte_at(j)];
                if (j == first || d == '0) break;
                j--;
            end
            if (d != '0) begin
                if (i >= n) break;
                total++;
                i += skip;
            end else begin
                i = j + m;
            end
        end
        return total;
    endfunction

    // Prediction on every accepted input transaction and on register writes.
    always @(posedge aclk) begin
        out_item_t res;
        if (!aresetn) begin
            pat_len      = 6'd2;
            pat_seen     = 0;
            txt_seen     = 0;
            txt_overflow = 1'b0;
        end else begin
            if (cfg_wr_en) pat_len = cfg_wr_data;
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_PATTERN) begin
                    if (pat_seen < PAT_MAX) begin
                        pat_mem[pat_seen] = s_data.data_byte;
                        pat_seen++;
                    end
                end else begin
                    if (txt_seen < TXT_DEPTH) begin
                        txt_mem[txt_seen] = s_data.data_byte;
                        txt_seen++;
                    end else begin
                        txt_overflow = 1'b1;
                    end
                    if (s_data.is_last) begin
                        if (pat_len < 2 || pat_len > PAT_MAX) begin
                            res.match_count = '0;
                            res.status      = STAT_SHORT;
                        end else begin
                            res.match_count = COUNT_W'(count_occurrences(pat_len, txt_seen));
                            res.status      = txt_overflow ? STAT_OVERFLOW : STAT_OK;
                        end
                        count_fifo.push_back(res);
                        pat_seen     = 0;
                        txt_seen     = 0;
                        txt_overflow = 1'b0;
                    end
                end
            end
        end
    end

    // Comparison of each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (count_fifo.size() == 0) begin
                $error("unexpected result: match_count %0d status %0d",
                       m_data.match_count, m_data.status);
                mismatches++;
            end else begin
                want = count_fifo.pop_front();
                if (m_data.match_count !== want.match_count) begin
                    $error("match_count: expected %0d, actual %0d",
                           want.match_count, m_data.match_count);
                    mismatches++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    mismatches++;
                end
            end
        end
    end

    assign waiting_counts = count_fifo.size();

    initial mismatches = 0;

endmodule

// ===== test/sbndm_string_match_counter_unit_test.sv =====
`timescale 1ns / 1ps

module sbndm_string_match_counter_unit_test;
    import sbndm_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    int         mismatches;
    int         waiting_counts;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         bytes_sent;
    logic       stall_req;
    logic       stall_done;
    int         stall_cycles;
    int         quiet_cycles;
    int         cur_len;
    logic [7:0] pattern_bytes [$];

    sbndm_string_match_counter_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    sbndm_match_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatches     (mismatches),
        .waiting_counts (waiting_counts)
    );

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        stall_req   = 1'b0;
        stall_done  = 1'b0;
        stall_cycles = 0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off when requested.
    always @(posedge aclk) begin
        if (stall_req && !stall_done) begin
            m_ready <= 1'b0;
            stall_cycles++;
            if (stall_cycles >= 400) stall_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one input transaction, with random idle cycles ahead of it.
    task automatic send_byte(input logic kind, input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data.req_type  <= kind;
        s_data.data_byte <= value;
        s_data.is_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Waits until every count has come back and the block is idle again.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (waiting_counts != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_len(input int len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LEN_W'(len);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_len = len;
    endtask

    function automatic logic [7:0] pick_byte(input int alpha, input logic [7:0] base);
        return (alpha == 0) ? 8'($urandom) : base + 8'($urandom_range(alpha - 1));
    endfunction

    // One search: pattern bytes, then text drawn mostly from a small alphabet so that
    // hits are common, sometimes with copies of the pattern spliced in.
    task automatic one_search(input int npat, input int ntext, input int alpha);
        logic [7:0] base;
        logic [7:0] b;
        int         t;
        base = 8'($urandom);
        pattern_bytes.delete();
        for (int k = 0; k < npat; k++) begin
            b = pick_byte(alpha, base);
            pattern_bytes.push_back(b);
            // The last mark on a pattern byte is ignored by the block.
            send_byte(REQ_PATTERN, b, $urandom_range(9) == 0);
        end
        t = 0;
        while (t < ntext) begin
            if (npat > 0 && $urandom_range(4) == 0) begin
                for (int k = 0; k < npat && t < ntext; k++, t++)
                    send_byte(REQ_TEXT, pattern_bytes[k], t == ntext - 1);
            end else begin
                send_byte(REQ_TEXT, pick_byte(alpha, base), t == ntext - 1);
                t++;
            end
        end
    endtask

    initial begin
        int plen;
        int npat;
        int ntext;
        quiet_cycles  = 0;
        bytes_sent    = 0;
        send_idle_pct = 23;
        recv_idle_pct = 77;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unusable lengths, extreme bytes, hit at position zero,
        // text shorter than the pattern.
        write_len(0);
        send_byte(REQ_PATTERN, 8'h00, 1'b0);
        send_byte(REQ_PATTERN, 8'hFF, 1'b0);
        send_byte(REQ_TEXT, 8'h00, 1'b1);
        write_len(1);
        send_byte(REQ_TEXT, 8'hFF, 1'b1);
        write_len(63);
        send_byte(REQ_TEXT, 8'h5A, 1'b1);
        write_len(33);
        send_byte(REQ_TEXT, 8'hA5, 1'b1);
        write_len(2);
        send_byte(REQ_PATTERN, 8'h00, 1'b1);
        send_byte(REQ_PATTERN, 8'hFF, 1'b0);
        send_byte(REQ_TEXT, 8'h00, 1'b0);
        send_byte(REQ_TEXT, 8'hFF, 1'b1);
        write_len(3);
        send_byte(REQ_PATTERN, 8'hFF, 1'b0);
        send_byte(REQ_PATTERN, 8'hFF, 1'b0);
        send_byte(REQ_PATTERN, 8'hFF, 1'b0);
        send_byte(REQ_TEXT, 8'hFF, 1'b0);
        send_byte(REQ_TEXT, 8'hFF, 1'b1);
        send_byte(REQ_PATTERN, 8'h00, 1'b0);
        send_byte(REQ_PATTERN, 8'h00, 1'b0);
        send_byte(REQ_PATTERN, 8'h00, 1'b0);
        send_byte(REQ_TEXT, 8'h00, 1'b0);
        send_byte(REQ_TEXT, 8'h00, 1'b0);
        send_byte(REQ_TEXT, 8'h00, 1'b1);

        // Random searches over three idling phases.
        while (bytes_sent < 1400) begin
            if (bytes_sent >= 470 && bytes_sent < 940) begin
                send_idle_pct = 77;
                recv_idle_pct = 23;
            end else if (bytes_sent >= 940) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                stall_req    <= 1'b1;
            end
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(19))
                    0:       plen = $urandom_range(1);
                    1:       plen = $urandom_range(63, 33);
                    2:       plen = 32;
                    3, 4:    plen = $urandom_range(31, 9);
                    default: plen = $urandom_range(8, 2);
                endcase
                write_len(plen);
            end
            if (cur_len >= 2 && cur_len <= 32) begin
                npat  = ($urandom_range(9) == 0) ? cur_len + $urandom_range(3) : cur_len;
                ntext = ($urandom_range(19) == 0) ? $urandom_range(300, 1)
                                                 : $urandom_range(3 * cur_len + 20, 1);
            end else begin
                npat  = $urandom_range(3);
                ntext = $urandom_range(4, 1);
            end
            case ($urandom_range(3))
                0:       one_search(npat, ntext, 0);
                1:       one_search(npat, ntext, 3);
                default: one_search(npat, ntext, 2);
            endcase
        end

        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && waiting_counts == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/sbndm_pkg.sv
src/sbndm_ctrl.sv
src/sbndm_datapath.sv
src/sbndm_string_match_counter_unit.sv
test/sbndm_match_checker.sv
test/sbndm_string_match_counter_unit_test.sv
